FILE: design/tbrl_pkg.sv
// tbrl_pkg: widths, reset values and register indexes of the token bucket rate limiter
// used by the channel interfaces and by the top level; depends on nothing

package tbrl_pkg;

  // field widths
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned CAP_W    = 20;
  localparam int unsigned DROP_W   = 64;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 1'd1;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 32'd2000;
  localparam logic [CAP_W-1:0]    CAPACITY_RST = 20'd500000;

endpackage

FILE: design/tbrl_if.sv
// tbrl_in_if / tbrl_out_if: valid/ready channels of the token bucket rate limiter
// depends on tbrl_pkg for the payload widths

interface tbrl_in_if;
  logic                           valid;
  logic                           ready;
  logic [tbrl_pkg::TIME_W-1:0]    event_time_ns;

  modport source (output valid, output event_time_ns, input ready);
  modport sink   (input valid, input event_time_ns, output ready);
endinterface

interface tbrl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           admitted;
  logic [tbrl_pkg::CAP_W-1:0]     tokens_left;
  logic [tbrl_pkg::DROP_W-1:0]    drops_total;

  modport source (output valid, output admitted, output tokens_left, output drops_total,
                  input ready);
  modport sink   (input valid, input admitted, input tokens_left, input drops_total,
                  output ready);
endinterface

FILE: design/token_bucket_rate_limiter.sv
// token_bucket_rate_limiter: admits or drops timestamped events against a token bucket
// depends on tbrl_pkg and on the channel interfaces in tbrl_if.sv
//
//   channel  direction  payload                                   handshake
//   in_ch    sink       event_time_ns[63:0]                       valid/ready
//   out_ch   source     admitted, tokens_left[19:0], drops_total  valid/ready
//   cfg      write      cfg_index[0], cfg_wdata[31:0]             cfg_we, no wait
//
// an event that starts the bucket goes from S_PREP straight to S_EMIT; any other event
// passes through S_DIV, where the restoring divider finds elapsed / period one quotient
// bit per cycle with one shared 33-bit compare-and-subtract unit, and then S_REFILL.
// in_ch.ready is high only while the sequencer is idle; a result waits in the output
// register, and the next result is held back until it has been taken.
// rst_n is synchronous; it clears the bucket state and restores the register defaults.

module token_bucket_rate_limiter (
  input  logic                            clk,
  input  logic                            rst_n,
  tbrl_in_if.sink                         in_ch,
  tbrl_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbrl_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned TW = tbrl_pkg::TIME_W;
  localparam int unsigned PW = tbrl_pkg::PERIOD_W;
  localparam int unsigned CW = tbrl_pkg::CAP_W;
  localparam int unsigned DW = tbrl_pkg::DROP_W;
  localparam int unsigned STEP_W = $clog2(TW);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_REFILL = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [PW-1:0]     period_r, period_nxt;
  logic [CW-1:0]     cap_r, cap_nxt;
  logic [TW-1:0]     last_r, last_nxt;
  logic [CW-1:0]     tokens_r, tokens_nxt;
  logic [DW-1:0]     drops_r, drops_nxt;
  logic [TW-1:0]     now_r, now_nxt;
  logic [TW-1:0]     quot_r, quot_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              admitted_r, admitted_nxt;
  logic [CW-1:0]     tokens_left_r, tokens_left_nxt;
  logic [DW-1:0]     drops_total_r, drops_total_nxt;

  logic [PW-1:0]     period_eff;
  logic [PW:0]       rem_shift;
  logic [PW:0]       rem_diff;
  logic              rem_ge;
  logic [CW:0]       refill_sum;
  logic              out_free;

  // a zero period counts as one nanosecond
  assign period_eff = (period_r == '0) ? {{(PW-1){1'b0}}, 1'b1} : period_r;

  // shared compare-and-subtract unit: one restoring division step
  assign rem_shift = {rem_r, quot_r[TW-1]};
  assign rem_diff  = rem_shift - {1'b0, period_eff};
  assign rem_ge    = ~rem_diff[PW];

  // saturating refill sum, used only when the quotient is below capacity
  assign refill_sum = {1'b0, tokens_r} + {1'b0, quot_r[CW-1:0]};

  assign out_free = ~out_valid_r | out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.admitted    = admitted_r;
  assign out_ch.tokens_left = tokens_left_r;
  assign out_ch.drops_total = drops_total_r;

  // sequencer and datapath next state
  always_comb begin
    state_nxt       = state_r;
    period_nxt      = period_r;
    cap_nxt         = cap_r;
    last_nxt        = last_r;
    tokens_nxt      = tokens_r;
    drops_nxt       = drops_r;
    now_nxt         = now_r;
    quot_nxt        = quot_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r & ~out_ch.ready;
    admitted_nxt    = admitted_r;
    tokens_left_nxt = tokens_left_r;
    drops_total_nxt = drops_total_r;

    // register writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we) begin
      if (cfg_index == tbrl_pkg::CFG_IDX_PERIOD) begin
        period_nxt = cfg_wdata[PW-1:0];
      end else if (cfg_index == tbrl_pkg::CFG_IDX_CAPACITY) begin
        cap_nxt = cfg_wdata[CW-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          now_nxt   = in_ch.event_time_ns;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // not started: take the event time and fill the bucket, nothing elapsed
        if (last_r == '0) begin
          last_nxt   = now_r;
          tokens_nxt = cap_r;
          state_nxt  = S_EMIT;
        end else begin
          quot_nxt  = now_r - last_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        quot_nxt = {quot_r[TW-2:0], rem_ge};
        rem_nxt  = rem_ge ? rem_diff[PW-1:0] : rem_shift[PW-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(TW - 1)) begin
          state_nxt = S_REFILL;
        end
      end
      S_REFILL: begin
        // a non-zero quotient means at least one period has elapsed
        if (quot_r != '0) begin
          last_nxt = now_r;
          if (quot_r >= {{(TW-CW){1'b0}}, cap_r}) begin
            tokens_nxt = cap_r;
          end else if (refill_sum > {1'b0, cap_r}) begin
            tokens_nxt = cap_r;
          end else begin
            tokens_nxt = refill_sum[CW-1:0];
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // admit or drop once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (tokens_r == '0) begin
            drops_nxt       = drops_r + 1'b1;
            admitted_nxt    = 1'b0;
            tokens_left_nxt = tokens_r;
            drops_total_nxt = drops_r + 1'b1;
          end else begin
            tokens_nxt      = tokens_r - 1'b1;
            admitted_nxt    = 1'b1;
            tokens_left_nxt = tokens_r - 1'b1;
            drops_total_nxt = drops_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and bucket state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= tbrl_pkg::PERIOD_RST;
      cap_r       <= tbrl_pkg::CAPACITY_RST;
      last_r      <= '0;
      tokens_r    <= '0;
      drops_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      cap_r       <= cap_nxt;
      last_r      <= last_nxt;
      tokens_r    <= tokens_nxt;
      drops_r     <= drops_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    quot_r        <= quot_nxt;
    rem_r         <= rem_nxt;
    admitted_r    <= admitted_nxt;
    tokens_left_r <= tokens_left_nxt;
    drops_total_r <= drops_total_nxt;
  end

endmodule
